>>> hw/rtl/svf_pkg.sv
// Shared types and constants for the state variable filter step block.
`timescale 1ns / 1ps

package svf_pkg;

    // Default widths of samples and coefficients
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 32;

    // Integrator state width and internal arithmetic widths
    localparam int STATE_BITS     = 32;
    localparam int DIFF_BITS      = STATE_BITS + 1;
    localparam int SUM_BITS       = 44;
    localparam int MAG_BITS       = 42;
    localparam int DIGIT_BITS     = MAG_BITS / 2;
    localparam int PROD_MAG_BITS  = 41;
    localparam int COEFF_INT_BITS = 8;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STATE_GAIN   = 2'd0,
        REG_MIX_GAIN     = 2'd1,
        REG_FEED_GAIN    = 2'd2,
        REG_DAMPING_GAIN = 2'd3
    } cfg_reg_t;

    // Products formed in turn on the shared multiplier
    typedef enum logic [2:0] {
        PROD_STATE_S1  = 3'd0,
        PROD_MIX_DIFF  = 3'd1,
        PROD_MIX_S1    = 3'd2,
        PROD_FEED_DIFF = 3'd3,
        PROD_DAMP_BAND = 3'd4
    } prod_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_OPER   = 3'd1,
        ST_MUL_LO = 3'd2,
        ST_MUL_HI = 3'd3,
        ST_ROUND  = 3'd4,
        ST_ACC    = 3'd5,
        ST_FINISH = 3'd6
    } svf_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;
        logic      oper;
        logic      mul_lo;
        logic      mul_hi;
        logic      round;
        logic      acc;
        logic      finish;
        prod_sel_t prod;
    } dp_cmd_t;

endpackage

>>> hw/rtl/svf_sample_if.sv
// Input sample channel: valid/ready request carrying one audio sample.
`timescale 1ns / 1ps

interface svf_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

>>> hw/rtl/svf_result_if.sv
// Result channel: valid/ready request carrying lowpass, band and highpass values.
`timescale 1ns / 1ps

interface svf_result_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] low_out;
    logic signed [SAMPLE_BITS-1:0] band_out;
    logic signed [SAMPLE_BITS-1:0] high_out;

    modport source (output valid, output low_out, output band_out, output high_out,
                    input ready);
    modport sink   (input valid, input low_out, input band_out, input high_out,
                    output ready);
endinterface

>>> hw/rtl/svf_cfg_if.sv
// Configuration write channel: valid/ready request with register index and data.
`timescale 1ns / 1ps

interface svf_cfg_if
    import svf_pkg::*;
#(
    parameter int COEFF_BITS = 32
);
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COEFF_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/svf_ctrl.sv
// Sequencing state machine: steps the datapath through the five products per sample.
`timescale 1ns / 1ps

module svf_ctrl
    import svf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    output logic    result_valid,
    input  logic    result_ready,
    output dp_cmd_t cmd
);

    svf_state_t state_reg, state_next;
    prod_sel_t  prod_reg, prod_next;
    logic       out_valid_reg, out_valid_next;

    // Order in which the products are taken; band is complete before damping needs it
    function automatic prod_sel_t next_prod(input prod_sel_t p);
        prod_sel_t n;
        unique case (p)
            PROD_STATE_S1:  n = PROD_MIX_DIFF;
            PROD_MIX_DIFF:  n = PROD_MIX_S1;
            PROD_MIX_S1:    n = PROD_FEED_DIFF;
            PROD_FEED_DIFF: n = PROD_DAMP_BAND;
            default:        n = PROD_STATE_S1;
        endcase
        return n;
    endfunction

    // State, product counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prod_reg      <= PROD_STATE_S1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        prod_next    = prod_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        cmd.prod     = prod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    prod_next  = PROD_STATE_S1;
                    state_next = ST_OPER;
                end
            end
            ST_OPER:
            begin
                cmd.oper   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (prod_reg == PROD_DAMP_BAND)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    prod_next  = next_prod(prod_reg);
                    state_next = ST_OPER;
                end
            end
            ST_FINISH:
            begin
                // wait until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/svf_dpath.sv
// Datapath: coefficient registers, integrator states, shared digit multiplier and sums.
`timescale 1ns / 1ps

module svf_dpath
    import svf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEFF_BITS-1:0]         cfg_data,
    output logic signed [SAMPLE_BITS-1:0] low_out,
    output logic signed [SAMPLE_BITS-1:0] band_out,
    output logic signed [SAMPLE_BITS-1:0] high_out
);

    localparam int FRAC       = COEFF_BITS - COEFF_INT_BITS;
    localparam int PART_BITS  = COEFF_BITS + DIGIT_BITS;
    localparam int ACC_BITS   = COEFF_BITS + MAG_BITS;
    localparam int SHIFT_BITS = ACC_BITS + 1 - FRAC;
    localparam int WIDE_BITS  = SUM_BITS + 2;

    localparam logic [ACC_BITS:0] HALF = (ACC_BITS + 1)'(1) << (FRAC - 1);
    localparam logic [PROD_MAG_BITS-1:0] PROD_LIMIT = {1'b1, {(PROD_MAG_BITS-1){1'b0}}};
    localparam logic [SHIFT_BITS-1:0] SHIFT_LIMIT =
        {{(SHIFT_BITS-PROD_MAG_BITS){1'b0}}, PROD_LIMIT};

    // Coefficients
    logic [COEFF_BITS-1:0] state_gain_reg, mix_gain_reg, feed_gain_reg, damping_gain_reg;

    // Integrator states and per-sample working values
    logic signed [STATE_BITS-1:0] s1_reg, s2_reg;
    logic signed [SUM_BITS-1:0]   x_reg, band_reg, low_reg, high_reg;
    logic signed [DIFF_BITS-1:0]  diff_reg;

    // Multiplier operands and product
    logic [COEFF_BITS-1:0]    cmag_reg;
    logic [MAG_BITS-1:0]      vmag_reg;
    logic                     neg_reg;
    logic [ACC_BITS-1:0]      acc_reg;
    logic [PROD_MAG_BITS-1:0] mag_reg;

    logic signed [SAMPLE_BITS-1:0] low_out_reg, band_out_reg, high_out_reg;

    logic [COEFF_BITS-1:0]        c_sel, c_mag;
    logic signed [SUM_BITS-1:0]   v_sel;
    logic [SUM_BITS-1:0]          v_mag;
    logic [DIGIT_BITS-1:0]        digit;
    logic [PART_BITS-1:0]         part;
    logic [ACC_BITS:0]            rsum;
    logic [SHIFT_BITS-1:0]        shifted;
    logic signed [SUM_BITS-1:0]   mag_ext, x_minus_low;
    logic signed [WIDE_BITS-1:0]  s1_wide, s2_wide;

    // Clamp a wide value to the integrator range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-STATE_BITS:0] top;
        logic signed [STATE_BITS-1:0]  r;
        top = v[WIDE_BITS-1:STATE_BITS-1];
        if ((&top) || !(|top))
        begin
            r = v[STATE_BITS-1:0];
        end
        else if (v[WIDE_BITS-1])
        begin
            r = {1'b1, {(STATE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Clamp a sum to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_BITS-1:0] v);
        logic [SUM_BITS-SAMPLE_BITS:0] top;
        logic signed [SAMPLE_BITS-1:0] r;
        top = v[SUM_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        else if (v[SUM_BITS-1])
        begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // Coefficient register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_gain_reg   <= '0;
            mix_gain_reg     <= '0;
            feed_gain_reg    <= '0;
            damping_gain_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STATE_GAIN:   state_gain_reg   <= cfg_data;
                REG_MIX_GAIN:     mix_gain_reg     <= cfg_data;
                REG_FEED_GAIN:    feed_gain_reg    <= cfg_data;
                REG_DAMPING_GAIN: damping_gain_reg <= cfg_data;
            endcase
        end
    end

    // Operand selection for the current product
    always_comb
    begin
        unique case (cmd.prod)
            PROD_STATE_S1:
            begin
                c_sel = state_gain_reg;
                v_sel = SUM_BITS'(s1_reg);
            end
            PROD_MIX_DIFF:
            begin
                c_sel = mix_gain_reg;
                v_sel = SUM_BITS'(diff_reg);
            end
            PROD_MIX_S1:
            begin
                c_sel = mix_gain_reg;
                v_sel = SUM_BITS'(s1_reg);
            end
            PROD_FEED_DIFF:
            begin
                c_sel = feed_gain_reg;
                v_sel = SUM_BITS'(diff_reg);
            end
            PROD_DAMP_BAND:
            begin
                c_sel = damping_gain_reg;
                v_sel = band_reg;
            end
            default:
            begin
                c_sel = '0;
                v_sel = '0;
            end
        endcase
    end

    // Magnitudes; a full-scale negative coefficient still fits unsigned
    assign c_mag = c_sel[COEFF_BITS-1] ? (~c_sel + COEFF_BITS'(1)) : c_sel;
    assign v_mag = v_sel[SUM_BITS-1] ? (~v_sel + SUM_BITS'(1)) : v_sel;

    // One digit of the value magnitude per multiplier pass
    assign digit = cmd.mul_hi ? vmag_reg[MAG_BITS-1:DIGIT_BITS] : vmag_reg[DIGIT_BITS-1:0];
    assign part  = {{DIGIT_BITS{1'b0}}, cmag_reg} * {{COEFF_BITS{1'b0}}, digit};

    // Round half away from zero on the magnitude, then clamp
    assign rsum    = {1'b0, acc_reg} + HALF;
    assign shifted = rsum[ACC_BITS:FRAC];

    assign mag_ext     = $signed({{(SUM_BITS-PROD_MAG_BITS){1'b0}}, mag_reg});
    assign x_minus_low = x_reg - low_reg;

    assign s1_wide = (WIDE_BITS'(band_reg) <<< 1) - WIDE_BITS'(s1_reg);
    assign s2_wide = (WIDE_BITS'(low_reg) <<< 1) - WIDE_BITS'(s2_reg);

    // Integrator states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (cmd.finish)
        begin
            s1_reg <= sat_state(s1_wide);
            s2_reg <= sat_state(s2_wide);
        end
    end

    // Working registers of the sample in flight
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= SUM_BITS'(sample_in);
            diff_reg <= DIFF_BITS'(sample_in) - DIFF_BITS'(s2_reg);
            band_reg <= '0;
            low_reg  <= SUM_BITS'(s2_reg);
        end

        if (cmd.oper)
        begin
            cmag_reg <= c_mag;
            vmag_reg <= v_mag[MAG_BITS-1:0];
            neg_reg  <= c_sel[COEFF_BITS-1] ^ v_sel[SUM_BITS-1];
        end

        if (cmd.mul_lo)
        begin
            acc_reg <= {{(ACC_BITS-PART_BITS){1'b0}}, part};
        end
        else if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + {part, {DIGIT_BITS{1'b0}}};
        end

        if (cmd.round)
        begin
            mag_reg <= (shifted > SHIFT_LIMIT) ? PROD_LIMIT : shifted[PROD_MAG_BITS-1:0];
        end

        // Signed accumulate of the finished product into its sum
        if (cmd.acc)
        begin
            unique case (cmd.prod)
                PROD_STATE_S1, PROD_MIX_DIFF:
                begin
                    band_reg <= neg_reg ? (band_reg - mag_ext) : (band_reg + mag_ext);
                end
                PROD_MIX_S1, PROD_FEED_DIFF:
                begin
                    low_reg <= neg_reg ? (low_reg - mag_ext) : (low_reg + mag_ext);
                end
                PROD_DAMP_BAND:
                begin
                    high_reg <= neg_reg ? (x_minus_low + mag_ext) : (x_minus_low - mag_ext);
                end
                default:
                begin
                    high_reg <= high_reg;
                end
            endcase
        end

        // Output register
        if (cmd.finish)
        begin
            low_out_reg  <= sat_sample(low_reg);
            band_out_reg <= sat_sample(band_reg);
            high_out_reg <= sat_sample(high_reg);
        end
    end

    assign low_out  = low_out_reg;
    assign band_out = band_out_reg;
    assign high_out = high_out_reg;

endmodule

>>> hw/rtl/state_variable_filter_step_top.sv
// A result becomes valid after all five products and the state update, once the output register is free.
// Samples are taken only when idle, so one at a time; each of the five products passes the one shared
// multiplier as operand load, low digit and high digit, then rounding and accumulate, then a state update.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n low, asynchronous): coefficients and integrator states clear to zero, idle.
`timescale 1ns / 1ps

module state_variable_filter_step_top
    import svf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    svf_sample_if.sink    sample,
    svf_result_if.source  result,
    svf_cfg_if.sink       cfg
);

    dp_cmd_t cmd;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    // Sequencer
    svf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    // Arithmetic and storage
    svf_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample_in (sample.sample_in),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .low_out   (result.low_out),
        .band_out  (result.band_out),
        .high_out  (result.high_out)
    );

endmodule

>>> dv/state_variable_filter_step_top_test.sv
// Self-checking testbench for the state variable filter step block.
`timescale 1ns / 1ps

module state_variable_filter_step_top_test
    import svf_pkg::*;
();

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int CB         = COEFF_BITS_DEF;
    localparam int COEFF_FRAC = CB - COEFF_INT_BITS;
    localparam int SETTLE_CYCLES = 30;       // block latency plus margin
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 100;

    localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [CB-1:0] GAIN_MAX   = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] GAIN_MIN   = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] GAIN_ONE   = CB'(1) << COEFF_FRAC;

    typedef struct packed {
        logic [SB-1:0] low_val;
        logic [SB-1:0] band_val;
        logic [SB-1:0] high_val;
    } filter_outputs_t;

    // Filter predictor and queue of expected outputs
    class svf_scoreboard;
        logic signed [CB-1:0] gain [4];
        longint               integ1;
        longint               integ2;
        filter_outputs_t      pending_outputs [$];
        int                   errors;

        function new();
            for (int i = 0; i < 4; i++)
                gain[i] = '0;
            integ1 = 0;
            integ2 = 0;
            errors = 0;
        endfunction

        function void set_gain(cfg_reg_t idx, logic [CB-1:0] value);
            gain[int'(idx)] = value;
        endfunction

        function int pending_count();
            return pending_outputs.size();
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // coefficient times value, rounded half away from zero, magnitude capped at 2^40
        function longint scale_product(longint c, longint v);
            bit         neg;
            bit [127:0] ua;
            bit [127:0] ub;
            bit [127:0] mag;
            neg = (c < 0) != (v < 0);
            ua  = (c < 0) ? 128'(-c) : 128'(c);
            ub  = (v < 0) ? 128'(-v) : 128'(v);
            mag = (ua * ub + (128'd1 << (COEFF_FRAC - 1))) >> COEFF_FRAC;
            if (mag > (128'd1 << 40))
                mag = 128'd1 << 40;
            return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        endfunction

        // One filter step for an accepted sample request
        function void take_sample(logic [SB-1:0] raw);
            longint          x;
            longint          diff;
            longint          band;
            longint          lowp;
            longint          highp;
            filter_outputs_t res;
            x     = longint'($signed(raw));
            diff  = x - integ2;
            band  = scale_product(longint'(gain[REG_STATE_GAIN]), integ1)
                  + scale_product(longint'(gain[REG_MIX_GAIN]), diff);
            lowp  = scale_product(longint'(gain[REG_MIX_GAIN]), integ1) + integ2
                  + scale_product(longint'(gain[REG_FEED_GAIN]), diff);
            highp = x - scale_product(longint'(gain[REG_DAMPING_GAIN]), band) - lowp;
            integ1 = clamp(2 * band - integ1, STATE_BITS);
            integ2 = clamp(2 * lowp - integ2, STATE_BITS);
            res.low_val  = SB'(clamp(lowp, SB));
            res.band_val = SB'(clamp(band, SB));
            res.high_val = SB'(clamp(highp, SB));
            pending_outputs.push_back(res);
        endfunction

        function void check_outputs(logic [SB-1:0] lo, logic [SB-1:0] bd, logic [SB-1:0] hi);
            filter_outputs_t exp_res;
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result: low %0d band %0d high %0d",
                       $signed(lo), $signed(bd), $signed(hi));
                errors++;
                return;
            end
            exp_res = pending_outputs.pop_front();
            if (lo !== exp_res.low_val)
            begin
                $error("low_out expected %0d got %0d", $signed(exp_res.low_val), $signed(lo));
                errors++;
            end
            if (bd !== exp_res.band_val)
            begin
                $error("band_out expected %0d got %0d", $signed(exp_res.band_val), $signed(bd));
                errors++;
            end
            if (hi !== exp_res.high_val)
            begin
                $error("high_out expected %0d got %0d", $signed(exp_res.high_val), $signed(hi));
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;

    svf_scoreboard book = new();

    svf_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
    svf_result_if #(.SAMPLE_BITS(SB)) result_ch ();
    svf_cfg_if    #(.COEFF_BITS(CB))  cfg_ch ();

    state_variable_filter_step_top #(
        .SAMPLE_BITS(SB),
        .COEFF_BITS (CB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("state_variable_filter_step_top: mismatch");
            $finish;
        end
    end

    // Result side: ready in runs of random length, with occasional long free stretches
    initial
    begin
        bit hold;
        int run_left;
        hold     = 1'b0;
        run_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                hold = ~hold;
                if (hold)
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                           : $urandom_range(1, 40);
                else
                    run_left = $urandom_range(1, 30);
            end
            run_left--;
            result_ch.ready <= hold;
        end
    end

    // Result checking at the rising edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                book.check_outputs(result_ch.low_out, result_ch.band_out, result_ch.high_out);
        end
    end

    // Present one sample request; called at a falling edge, returns at a falling edge
    task automatic push_sample(input logic [SB-1:0] x);
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= x;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        book.take_sample(x);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CB-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        book.set_gain(idx, value);
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        while (book.pending_count() != 0)
            @(negedge clk);
    endtask

    // Coefficients change only once the block has gone quiet
    task automatic set_gains(input logic [CB-1:0] g_state, input logic [CB-1:0] g_mix,
                             input logic [CB-1:0] g_feed, input logic [CB-1:0] g_damp);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_STATE_GAIN, g_state);
        write_reg(REG_MIX_GAIN, g_mix);
        write_reg(REG_FEED_GAIN, g_feed);
        write_reg(REG_DAMPING_GAIN, g_damp);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_list(input logic [SB-1:0] xs [$]);
        foreach (xs[i])
            push_sample(xs[i]);
        sample_ch.valid <= 1'b0;
    endtask

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SB'($urandom_range(0, 511) - 256);
            3:       return $urandom_range(0, 1) ? '1 : '0;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_gain(int kind);
        case (kind)
            1:       return CB'($urandom);
            2:
            begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return GAIN_MAX;
                    2:       return GAIN_MIN;
                    3:       return GAIN_ONE;
                    4:       return -GAIN_ONE;
                    default: return CB'(1);
                endcase
            end
            default: return CB'($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        endcase
    endfunction

    // Random sample stream, bursty or back to back, optionally draining half way
    task automatic send_random(input int n, input bit gappy, input bit pause_mid);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            push_sample(pick_sample());
            if (pause_mid && i == n / 2)
            begin
                sample_ch.valid <= 1'b0;
                @(negedge clk);
                drain_outputs();
            end
            else if (gappy)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    sample_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(negedge clk);
                    burst_left = $urandom_range(1, 24);
                end
            end
        end
        sample_ch.valid <= 1'b0;
    endtask

    // Main stimulus
    initial
    begin
        real g;
        real k;
        real a1;
        real a2;
        real a3;
        int  kind;
        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_STATE_GAIN;
        cfg_ch.data         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients: everything passes to the highpass
        send_list('{'0, SAMPLE_MAX, SAMPLE_MIN});

        // a plain lowpass-style setting, step up and step down
        set_gains(CB'(14588883), CB'(1458888), CB'(145889), CB'(23488102));
        send_list('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                    '0, SB'(1), '1});

        // largest coefficients: product, state and output saturation
        set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
        send_list('{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, '0});

        // most negative coefficients
        set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
        send_list('{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, '1});

        // band beyond the sample range feeding the highpass unsaturated
        set_gains(GAIN_ONE << 1, GAIN_ONE, '0, GAIN_ONE);
        send_list('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN});

        // random phases, each with its own coefficient set
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            kind = p % 4;
            if (kind == 0)
            begin
                g  = $urandom_range(1, 2000) / 1000.0;
                k  = $urandom_range(5, 200) / 100.0;
                a1 = 1.0 / (1.0 + g * (g + k));
                a2 = g * a1;
                a3 = g * a2;
                set_gains(CB'(int'(a1 * 16777216.0)), CB'(int'(a2 * 16777216.0)),
                          CB'(int'(a3 * 16777216.0)), CB'(int'(k * 16777216.0)));
            end
            else
                set_gains(pick_gain(kind), pick_gain(kind), pick_gain(kind), pick_gain(kind));
            send_random(PHASE_ITEMS, (p % 3) != 2, (p == 0) || ($urandom_range(0, 3) == 0));
        end

        // wind down
        while (book.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 10) @(posedge clk);
        if (book.errors == 0 && book.pending_count() == 0)
            $display("state_variable_filter_step_top: match");
        else
            $display("state_variable_filter_step_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/svf_pkg.sv
hw/rtl/svf_sample_if.sv
hw/rtl/svf_result_if.sv
hw/rtl/svf_cfg_if.sv
hw/rtl/svf_ctrl.sv
hw/rtl/svf_dpath.sv
hw/rtl/state_variable_filter_step_top.sv
dv/state_variable_filter_step_top_test.sv
